>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the clock and held off while reset is high.
`define QS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define QS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/qslerp_pkg.sv
// Types, constants and the arctangent table of the quaternion slerp unit.
package qslerp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ROOT_W       = 29;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int SQRT_STAGES  = ROOT_W;
   localparam int SIN_LAT      = CORDIC_STEPS + 1;
   localparam int DIV_STAGES   = 15;
   localparam int ANGLE_W      = 20;
   localparam int CORDIC_W     = 32;

   typedef logic signed [ANGLE_W-1:0]  angle_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;

   localparam angle_type  PI_Q16      = 20'sd205887;
   localparam angle_type  HALF_PI_Q16 = 20'sd102944;
   localparam angle_type  TWO_PI_Q16  = 20'sd411775;
   localparam cordic_type GAIN_Q28    = 32'sd163008219;

   typedef struct packed {
      logic [15:0]      blend_t;
      logic [3:0][15:0] p;
      logic [3:0][15:0] q;
   } side_type;

   typedef struct packed {
      logic             pass;
      logic [29:0]      d;
      logic [3:0][15:0] p;
   } back_type;

   // atan(2^-idx) in Q.16 radians, rounded to nearest.
   function automatic angle_type atan_q16(input int unsigned idx);
      case (idx)
         0:  return 20'sd51472;
         1:  return 20'sd30386;
         2:  return 20'sd16055;
         3:  return 20'sd8150;
         4:  return 20'sd4091;
         5:  return 20'sd2047;
         6:  return 20'sd1024;
         7:  return 20'sd512;
         8:  return 20'sd256;
         9:  return 20'sd128;
         10: return 20'sd64;
         11: return 20'sd32;
         12: return 20'sd16;
         13: return 20'sd8;
         14: return 20'sd4;
         15: return 20'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

>>> hw/rtl/qslerp_isqrt.sv
// Pipelined floor square root, one root bit per register stage.
module qslerp_isqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [qslerp_pkg::RAD_W-1:0]   radicand,
   output logic [qslerp_pkg::ROOT_W-1:0]  root
);
   import qslerp_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [RAD_W-1:0]  rad_ff  [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;

      if (i == 0) begin : g_head
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_body
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign cur   = {rem_prev, rad_prev[RAD_W-1-2*i -: 2]};
      assign trial = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            if (cur >= trial) begin
               rem_ff[i]  <= REM_W'(cur - trial);
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= REM_W'(cur);
               root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
            rad_ff[i] <= rad_prev;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

>>> hw/rtl/qslerp_sine.sv
// Pipelined sine: quadrant fold followed by a rotation CORDIC, one step per stage.
module qslerp_sine (
   input  logic                   clock,
   input  logic                   en,
   input  qslerp_pkg::angle_type  angle,
   output qslerp_pkg::cordic_type sine
);
   import qslerp_pkg::*;

   angle_type  wrap_a;
   angle_type  fold_a;
   angle_type  a0_ff;
   cordic_type x_ff [CORDIC_STEPS];
   cordic_type y_ff [CORDIC_STEPS];
   angle_type  z_ff [CORDIC_STEPS];

   // Bring the angle into [-pi/2, pi/2], where the CORDIC converges.
   always_comb begin
      wrap_a = (angle > PI_Q16) ? angle - TWO_PI_Q16 : angle;
      if (wrap_a > HALF_PI_Q16) begin
         fold_a = PI_Q16 - wrap_a;
      end else if (wrap_a < -HALF_PI_Q16) begin
         fold_a = -PI_Q16 - wrap_a;
      end else begin
         fold_a = wrap_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= fold_a;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cordic_type x_prev;
      cordic_type y_prev;
      angle_type  z_prev;

      if (i == 0) begin : g_head
         assign x_prev = GAIN_Q28;
         assign y_prev = '0;
         assign z_prev = a0_ff;
      end else begin : g_body
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (z_prev >= 0) begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
               z_ff[i] <= z_prev - atan_q16(i);
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
               z_ff[i] <= z_prev + atan_q16(i);
            end
         end
      end
   end

   assign sine = y_ff[CORDIC_STEPS-1];

endmodule

>>> hw/rtl/quaternion_slerp_unit.sv
// Top level of the quaternion spherical linear interpolation unit.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  blend_t, p_w..p_z, q_w..q_z
//   rsp      out        rsp_valid/rsp_stall  r_w..r_z, passed_start
//   csr      in/out     APB, pready high     angle_tolerance at byte 0
//
// The unit is a pipeline of 86 register stages, and one item can be accepted
// every cycle while no finished item is held at a stalled output.
// The depth is set by the 29-stage square root, the 16-stage arccosine
// CORDIC, the 17-stage sine CORDICs and the 15-stage quotient divider.
// Reset clears every stage's valid bit and sets angle_tolerance to 1.
// A stall on rsp freezes all stages at once; req_stall is high only while
// a finished item waits in the output register and rsp_stall is high.
module quaternion_slerp_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_blend_t,
   input  logic signed [15:0] req_p_w,
   input  logic signed [15:0] req_p_x,
   input  logic signed [15:0] req_p_y,
   input  logic signed [15:0] req_p_z,
   input  logic signed [15:0] req_q_w,
   input  logic signed [15:0] req_q_x,
   input  logic signed [15:0] req_q_y,
   input  logic signed [15:0] req_q_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_r_w,
   output logic signed [15:0] rsp_r_x,
   output logic signed [15:0] rsp_r_y,
   output logic signed [15:0] rsp_r_z,
   output logic               rsp_passed_start,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import qslerp_pkg::*;

   // Stage numbers, counted from the first register after the input.
   localparam int ST_DOT     = 2;
   localparam int ST_RAD     = 3;
   localparam int ST_ROOT    = ST_RAD + SQRT_STAGES;
   localparam int ST_SETUP   = ST_ROOT + 1;
   localparam int ST_VEC_END = ST_SETUP + CORDIC_STEPS;
   localparam int ST_THETA   = ST_VEC_END + 1;
   localparam int ST_ANG     = ST_THETA + 1;
   localparam int ST_SIN     = ST_ANG + SIN_LAT;
   localparam int ST_MUL     = ST_SIN + 1;
   localparam int ST_SUM     = ST_MUL + 1;
   localparam int ST_DIV_END = ST_SUM + DIV_STAGES;
   localparam int ST_OUT     = ST_DIV_END + 1;

   localparam int NUM_W = 49;

   localparam logic              REG_ANGLE_TOL = 1'b0;
   localparam logic signed [33:0] ONE_Q28_W    = 34'sd268435456;
   localparam logic [59:0]        ONE_SQ_Q56   = 60'h1 << 56;

   logic             adv;
   side_type         side_in;
   logic [15:0]      tol_ff;
   logic [ST_OUT:1]  valid_ff;
   side_type         side_ff [1:ST_SIN];

   logic signed [31:0] prod_ff [4];
   logic signed [33:0] dot_sum;
   logic signed [29:0] dot_clamp;
   logic signed [29:0] c_ff [ST_DOT:ST_ROOT];
   logic signed [59:0] c_sq;
   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W-1:0]  root;

   cordic_type  vx_ff [ST_SETUP:ST_VEC_END];
   cordic_type  vy_ff [ST_SETUP:ST_VEC_END];
   angle_type   vz_ff [ST_SETUP:ST_VEC_END];
   logic [17:0] theta_ff [ST_THETA:ST_SIN];

   logic signed [17:0] one_minus_t;
   logic signed [36:0] ang_a_prod;
   logic [33:0]        ang_b_prod;
   angle_type          ang_th_ff;
   angle_type          ang_a_ff;
   angle_type          ang_b_ff;
   cordic_type         sin_th;
   cordic_type         sin_a;
   cordic_type         sin_b;

   logic signed [47:0] pa_ff [4];
   logic signed [47:0] pb_ff [4];
   back_type           bk_ff [ST_MUL:ST_DIV_END];
   logic               pass_now;

   logic signed [NUM_W-1:0] num   [4];
   logic [NUM_W-1:0]        mag   [4];
   logic [NUM_W-1:0]        dividend [4];
   logic [3:0]              neg_now;
   logic [3:0]              sat_now;
   logic [NUM_W-1:0]        rem_ff [ST_SUM:ST_DIV_END][4];
   logic [DIV_STAGES-1:0]   quo_ff [ST_SUM:ST_DIV_END][4];
   logic [3:0]              neg_ff [ST_SUM:ST_DIV_END];
   logic [3:0]              sat_ff [ST_SUM:ST_DIV_END];

   logic signed [15:0] r_ff [4];
   logic               passed_ff;

   // The whole pipeline moves together; it holds only when the output
   // register has an item that the receiver is not taking.
   assign adv       = !(valid_ff[ST_OUT] && rsp_stall);
   assign req_stall = !adv;

   assign side_in.blend_t = req_blend_t;
   assign side_in.p       = {req_p_z, req_p_y, req_p_x, req_p_w};
   assign side_in.q       = {req_q_z, req_q_y, req_q_x, req_q_w};

   // Configuration register. Writes must arrive only while the pipeline is empty; the block does not enforce it.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ANGLE_TOL) ? {16'b0, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 16'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_ANGLE_TOL) begin
         tol_ff <= csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ST_OUT-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[1] <= side_in;
         for (int k = 2; k <= ST_SIN; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Dot product: four exact products, then their sum clamped to [-1, 1].
   always_comb begin
      dot_sum = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];
      if (dot_sum > ONE_Q28_W) begin
         dot_clamp = 30'(ONE_Q28_W);
      end else if (dot_sum < -ONE_Q28_W) begin
         dot_clamp = 30'(-ONE_Q28_W);
      end else begin
         dot_clamp = 30'(dot_sum);
      end
   end

   assign c_sq = c_ff[ST_DOT] * c_ff[ST_DOT];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed(side_in.p[k]) * $signed(side_in.q[k]);
         end
         c_ff[ST_DOT] <= dot_clamp;
         for (int k = ST_DOT + 1; k <= ST_ROOT; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
         // The sine of the angle is sqrt(1 - c*c), taken from this radicand.
         rad_ff <= RAD_W'(ONE_SQ_Q56 - unsigned'(c_sq));
      end
   end

   qslerp_isqrt u_isqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (rad_ff),
      .root     (root)
   );

   // Arccosine as atan2(root, c) by a vectoring CORDIC. A negative cosine
   // is first turned by -pi/2 so the vector starts in the right half plane.
   always_ff @(posedge clock) begin
      if (adv) begin
         if (c_ff[ST_ROOT] < 0) begin
            vx_ff[ST_SETUP] <= CORDIC_W'({1'b0, root});
            vy_ff[ST_SETUP] <= -CORDIC_W'(c_ff[ST_ROOT]);
            vz_ff[ST_SETUP] <= HALF_PI_Q16;
         end else begin
            vx_ff[ST_SETUP] <= CORDIC_W'(c_ff[ST_ROOT]);
            vy_ff[ST_SETUP] <= CORDIC_W'({1'b0, root});
            vz_ff[ST_SETUP] <= '0;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (vy_ff[ST_SETUP+i] > 0) begin
               vx_ff[ST_SETUP+i+1] <= vx_ff[ST_SETUP+i] + (vy_ff[ST_SETUP+i] >>> i);
               vy_ff[ST_SETUP+i+1] <= vy_ff[ST_SETUP+i] - (vx_ff[ST_SETUP+i] >>> i);
               vz_ff[ST_SETUP+i+1] <= vz_ff[ST_SETUP+i] + atan_q16(i);
            end else begin
               vx_ff[ST_SETUP+i+1] <= vx_ff[ST_SETUP+i] - (vy_ff[ST_SETUP+i] >>> i);
               vy_ff[ST_SETUP+i+1] <= vy_ff[ST_SETUP+i] + (vx_ff[ST_SETUP+i] >>> i);
               vz_ff[ST_SETUP+i+1] <= vz_ff[ST_SETUP+i] - atan_q16(i);
            end
         end
         // Clamp theta to [0, pi].
         if (vz_ff[ST_VEC_END] < 0) begin
            theta_ff[ST_THETA] <= '0;
         end else if (vz_ff[ST_VEC_END] > PI_Q16) begin
            theta_ff[ST_THETA] <= 18'(PI_Q16);
         end else begin
            theta_ff[ST_THETA] <= vz_ff[ST_VEC_END][17:0];
         end
         for (int k = ST_THETA + 1; k <= ST_SIN; k++) begin
            theta_ff[k] <= theta_ff[k-1];
         end
      end
   end

   // Scale theta by (1 - t) and by t; both products floor to Q.16.
   assign one_minus_t = 18'sd32768 - $signed({2'b00, side_ff[ST_THETA].blend_t});
   assign ang_a_prod  = one_minus_t * $signed({1'b0, theta_ff[ST_THETA]});
   assign ang_b_prod  = side_ff[ST_THETA].blend_t * theta_ff[ST_THETA];

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_th_ff <= ANGLE_W'({1'b0, theta_ff[ST_THETA]});
         ang_a_ff  <= ANGLE_W'(ang_a_prod >>> 15);
         ang_b_ff  <= ANGLE_W'(ang_b_prod >> 15);
      end
   end

   qslerp_sine u_sin_th (
      .clock (clock),
      .en    (adv),
      .angle (ang_th_ff),
      .sine  (sin_th)
   );

   qslerp_sine u_sin_a (
      .clock (clock),
      .en    (adv),
      .angle (ang_a_ff),
      .sine  (sin_a)
   );

   qslerp_sine u_sin_b (
      .clock (clock),
      .en    (adv),
      .angle (ang_b_ff),
      .sine  (sin_b)
   );

   // Below the tolerance, or with no usable sin(theta) to divide by,
   // the start quaternion goes out unchanged.
   assign pass_now = (theta_ff[ST_SIN] < {2'b00, tol_ff}) || (sin_th <= 0);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            pa_ff[k] <= sin_a * $signed(side_ff[ST_SIN].p[k]);
            pb_ff[k] <= sin_b * $signed(side_ff[ST_SIN].q[k]);
         end
         bk_ff[ST_MUL].pass <= pass_now;
         bk_ff[ST_MUL].d    <= sin_th[29:0];
         bk_ff[ST_MUL].p    <= side_ff[ST_SIN].p;
      end
   end

   // Numerator magnitude with half the divisor added for round-to-nearest.
   // A quotient of 2^15 or more saturates, so only 15 quotient bits remain.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         num[k]      = NUM_W'(pa_ff[k]) + NUM_W'(pb_ff[k]);
         neg_now[k]  = num[k] < 0;
         mag[k]      = neg_now[k] ? unsigned'(-num[k]) : unsigned'(num[k]);
         dividend[k] = mag[k] + NUM_W'(bk_ff[ST_MUL].d >> 1);
         sat_now[k]  = dividend[k] >= (NUM_W'(bk_ff[ST_MUL].d) << DIV_STAGES);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            rem_ff[ST_SUM][k] <= dividend[k];
            quo_ff[ST_SUM][k] <= '0;
         end
         neg_ff[ST_SUM] <= neg_now;
         sat_ff[ST_SUM] <= sat_now;
         bk_ff[ST_SUM]  <= bk_ff[ST_MUL];
         // Restoring division, one quotient bit per stage, msb first.
         for (int j = 0; j < DIV_STAGES; j++) begin
            for (int k = 0; k < 4; k++) begin
               if (rem_ff[ST_SUM+j][k] >=
                   (NUM_W'(bk_ff[ST_SUM+j].d) << (DIV_STAGES - 1 - j))) begin
                  rem_ff[ST_SUM+j+1][k] <= rem_ff[ST_SUM+j][k] -
                     (NUM_W'(bk_ff[ST_SUM+j].d) << (DIV_STAGES - 1 - j));
                  quo_ff[ST_SUM+j+1][k] <= {quo_ff[ST_SUM+j][k][DIV_STAGES-2:0], 1'b1};
               end else begin
                  rem_ff[ST_SUM+j+1][k] <= rem_ff[ST_SUM+j][k];
                  quo_ff[ST_SUM+j+1][k] <= {quo_ff[ST_SUM+j][k][DIV_STAGES-2:0], 1'b0};
               end
            end
            neg_ff[ST_SUM+j+1] <= neg_ff[ST_SUM+j];
            sat_ff[ST_SUM+j+1] <= sat_ff[ST_SUM+j];
            bk_ff[ST_SUM+j+1]  <= bk_ff[ST_SUM+j];
         end
      end
   end

   // Output register: sign, saturation and the pass-through of p.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            if (bk_ff[ST_DIV_END].pass) begin
               r_ff[k] <= $signed(bk_ff[ST_DIV_END].p[k]);
            end else if (sat_ff[ST_DIV_END][k]) begin
               r_ff[k] <= neg_ff[ST_DIV_END][k] ? -16'sd32768 : 16'sd32767;
            end else if (neg_ff[ST_DIV_END][k]) begin
               r_ff[k] <= -$signed({1'b0, quo_ff[ST_DIV_END][k]});
            end else begin
               r_ff[k] <= $signed({1'b0, quo_ff[ST_DIV_END][k]});
            end
         end
         passed_ff <= bk_ff[ST_DIV_END].pass;
      end
   end

   assign rsp_valid        = valid_ff[ST_OUT];
   assign rsp_r_w          = r_ff[0];
   assign rsp_r_x          = r_ff[1];
   assign rsp_r_y          = r_ff[2];
   assign rsp_r_z          = r_ff[3];
   assign rsp_passed_start = passed_ff;

endmodule

>>> hw/rtl/qslerp_checker.sv
// Port-level checker for the quaternion slerp unit and its bind statement.
`include "assert_macros.svh"

module qslerp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [15:0]        req_blend_t,
   input logic signed [15:0] req_p_w,
   input logic signed [15:0] req_p_x,
   input logic signed [15:0] req_p_y,
   input logic signed [15:0] req_p_z,
   input logic signed [15:0] req_q_w,
   input logic signed [15:0] req_q_x,
   input logic signed [15:0] req_q_y,
   input logic signed [15:0] req_q_z,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_r_w,
   input logic signed [15:0] rsp_r_x,
   input logic signed [15:0] rsp_r_y,
   input logic signed [15:0] rsp_r_z,
   input logic               rsp_passed_start,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite,
   input logic [2:0]         csr_paddr,
   input logic [31:0]        csr_pwdata,
   input logic [31:0]        csr_prdata,
   input logic               csr_pready
);

   // The input side holds only while a finished item is held at the output.
   `QS_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "req stalled without a held result")

   // A held result is not withdrawn.
   `QS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp valid dropped while stalled")

   // Reset empties the pipeline.
   `QS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // A tolerance write reads back on the following cycle.
   `QS_ASSERT(a_csr_readback, clock, reset, (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) |=> (csr_paddr[2] != 1'b0 || csr_prdata[15:0] == $past(csr_pwdata[15:0])), "tolerance readback mismatch")

endmodule

bind quaternion_slerp_unit qslerp_checker u_qslerp_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the quaternion slerp unit.
`timescale 1ns / 100ps

module testbench;
   import qslerp_pkg::*;

   localparam logic [2:0] ANGLE_TOL_ADDR = 3'd0;
   localparam int         PIPE_DEPTH     = 86;
   localparam int         HOLD_CYCLES    = 400;
   localparam longint     ONE_Q15        = 32768;
   localparam longint     ONE_Q28        = 64'sd268435456;
   localparam longint     PI_VAL         = 205887;
   localparam longint     HALF_PI_VAL    = 102944;
   localparam longint     TWO_PI_VAL     = 411775;
   localparam longint     GAIN_VAL       = 163008219;

   // One interpolation request and the result it should produce.
   typedef struct {
      logic [15:0]        blend;
      logic signed [15:0] p [4];
      logic signed [15:0] q [4];
   } slerp_item_type;

   typedef struct {
      logic signed [15:0] r [4];
      logic               passed;
   } slerp_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_blend_t = '0;
   logic signed [15:0] req_p_w = '0, req_p_x = '0, req_p_y = '0, req_p_z = '0;
   logic signed [15:0] req_q_w = '0, req_q_x = '0, req_q_y = '0, req_q_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic               rsp_passed_start;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   quaternion_slerp_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be offered, and results still owed by the unit.
   slerp_item_type   pending_items[$];
   slerp_result_type owed_results[$];
   slerp_item_type   offered;

   longint tolerance_now = 1;   // our copy of angle_tolerance
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   int     mismatches = 0;
   logic   hold_armed = 1'b0;
   logic   hold_done = 1'b0;
   int     hold_left = 0;

   // Floor square root, bit by bit.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= res + bit_val) begin
            n -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   // Arccosine in Q.16 of a cosine in Q.28, via a vectoring CORDIC on
   // the point (c, sqrt(1 - c*c)).
   function automatic longint angle_of_cos(longint c);
      longint x, y, z, nx;
      z = 0;
      y = longint'(floor_sqrt(longint'(ONE_Q28 * ONE_Q28 - c * c)));
      x = c;
      if (x < 0) begin
         nx = y;
         y = -x;
         x = nx;
         z = HALF_PI_VAL;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(atan_q16(i));
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(atan_q16(i));
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (z > PI_VAL) z = PI_VAL;
      return z;
   endfunction

   // Sine in Q.28 of an angle in Q.16, folded into [-pi/2, pi/2] first.
   function automatic longint sine_q28(longint a);
      longint x, y, nx;
      x = GAIN_VAL;
      y = 0;
      if (a > PI_VAL) a -= TWO_PI_VAL;
      if (a > HALF_PI_VAL) a = PI_VAL - a;
      else if (a < -HALF_PI_VAL) a = -PI_VAL - a;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            a -= longint'(atan_q16(i));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            a += longint'(atan_q16(i));
         end
         x = nx;
      end
      return y;
   endfunction

   function automatic logic signed [15:0] quotient_sat(longint n, longint d);
      longint mag, quo;
      mag = (n < 0) ? -n : n;
      quo = (mag + d / 2) / d;
      if (n < 0) quo = -quo;
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      return quo[15:0];
   endfunction

   function automatic slerp_result_type slerp_of(slerp_item_type it);
      slerp_result_type res;
      longint c, theta, sin_theta, sin_a, sin_b, t;
      c = 0;
      t = longint'(it.blend);
      for (int k = 0; k < 4; k++) c += longint'(it.p[k]) * longint'(it.q[k]);
      if (c > ONE_Q28) c = ONE_Q28;
      if (c < -ONE_Q28) c = -ONE_Q28;
      theta = angle_of_cos(c);
      sin_theta = sine_q28(theta);
      // Small angles and a vanishing sine both hand back p unchanged.
      if (theta < tolerance_now || sin_theta <= 0) begin
         for (int k = 0; k < 4; k++) res.r[k] = it.p[k];
         res.passed = 1'b1;
         return res;
      end
      sin_a = sine_q28(((ONE_Q15 - t) * theta) >>> 15);
      sin_b = sine_q28((t * theta) >>> 15);
      for (int k = 0; k < 4; k++)
         res.r[k] = quotient_sat(sin_a * longint'(it.p[k]) + sin_b * longint'(it.q[k]),
                                 sin_theta);
      res.passed = 1'b0;
      return res;
   endfunction

   // Driver: keeps a stalled item steady, otherwise offers the next one
   // unless the sender is idling this cycle.
   always @(posedge clock) begin
      logic taken;
      taken = req_valid && !req_stall;
      if (taken) owed_results.push_back(slerp_of(offered));
      if (reset || (req_valid && !taken)) begin
         // hold the current payload
      end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         offered = pending_items.pop_front();
         req_valid   <= 1'b1;
         req_blend_t <= offered.blend;
         req_p_w <= offered.p[0];
         req_p_x <= offered.p[1];
         req_p_y <= offered.p[2];
         req_p_z <= offered.p[3];
         req_q_w <= offered.q[0];
         req_q_x <= offered.q[1];
         req_q_y <= offered.q[2];
         req_q_z <= offered.q[3];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Long receiver hold-off, counted here; armed once by the stimulus.
   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: checks each accepted result against the oldest one owed.
   always @(posedge clock) begin
      slerp_result_type want;
      logic signed [15:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z};
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item r=%0d %0d %0d %0d",
                                           got[0], got[1], got[2], got[3]);
         end else begin
            want = owed_results.pop_front();
            if (got != want.r || rsp_passed_start != want.passed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected r=%0d %0d %0d %0d pass=%0b, ",
                            "got %0d %0d %0d %0d pass=%0b"},
                           want.r[0], want.r[1], want.r[2], want.r[3], want.passed,
                           got[0], got[1], got[2], got[3], rsp_passed_start);
            end
         end
      end
      rsp_stall <= !reset && (hold_left > 0 || $urandom_range(99) < stall_pct);
   end

   function automatic slerp_item_type make_item(logic [15:0] t, int pw, int px, int py,
                                                int pz, int qw, int qx, int qy, int qz);
      slerp_item_type it;
      it.blend = t;
      it.p = '{pw[15:0], px[15:0], py[15:0], pz[15:0]};
      it.q = '{qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
      return it;
   endfunction

   // Random point on the unit sphere in Q2.14.
   task automatic unit_quat(output logic signed [15:0] v [4]);
      real comp [4];
      real norm;
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
         comp[k] = real'($urandom_range(32768)) - 16384.0;
         norm += comp[k] * comp[k];
      end
      if (norm < 1.0) begin
         comp[0] = 1.0;
         norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int k = 0; k < 4; k++) v[k] = 16'($rtoi(comp[k] * 16384.0 / norm));
   endtask

   // Mostly unit quaternions, some close to each other so the tolerance
   // matters, some opposite, and some raw noise to reach every bit and the clamp.
   task automatic add_random_items(int count);
      slerp_item_type it;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         it.blend = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
         if (pick < 25) begin
            for (int k = 0; k < 4; k++) begin
               it.p[k] = 16'($urandom);
               it.q[k] = 16'($urandom);
            end
         end else begin
            unit_quat(it.p);
            if (pick < 45) begin
               for (int k = 0; k < 4; k++)
                  it.q[k] = it.p[k] + $signed(16'($urandom_range(64))) - 16'sd32;
            end else if (pick < 50) begin
               for (int k = 0; k < 4; k++) it.q[k] = -it.p[k];
            end else begin
               unit_quat(it.q);
            end
         end
         pending_items.push_back(it);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      #1;
      while (pending_items.size() > 0 || req_valid || owed_results.size() > 0) begin
         @(posedge clock);
         #1;
      end
      // Let anything still in the pipeline come out.
      repeat (PIPE_DEPTH + 20) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ANGLE_TOL_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tolerance_now = longint'(value);
   endtask

   // Timeout guard.
   initial begin
      #5000000;
      $display("quaternion_slerp_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset tolerance: endpoints of t, identical
      // and opposite quaternions, extreme and zero components.
      pending_items.push_back(make_item(16'd0, 16384, 0, 0, 0, 0, 16384, 0, 0));
      pending_items.push_back(make_item(16'd32768, 16384, 0, 0, 0, 0, 16384, 0, 0));
      pending_items.push_back(make_item(16'd16384, 16384, 0, 0, 0, 0, 16384, 0, 0));
      pending_items.push_back(make_item(16'd65535, 16384, 0, 0, 0, 0, 16384, 0, 0));
      pending_items.push_back(make_item(16'd16384, 8192, 8192, 8192, 8192,
                                        8192, 8192, 8192, 8192));
      pending_items.push_back(make_item(16'd16384, 8192, -8192, 8192, 8192,
                                        -8192, 8192, -8192, -8192));
      pending_items.push_back(make_item(16'd10000, 32767, 32767, 32767, 32767,
                                        32767, 32767, 32767, 32767));
      pending_items.push_back(make_item(16'd10000, -32768, -32768, -32768, -32768,
                                        32767, 32767, 32767, 32767));
      pending_items.push_back(make_item(16'd20000, -32768, 32767, -32768, 32767,
                                        -32768, 32767, 0, 0));
      pending_items.push_back(make_item(16'd0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(16'd40000, 16384, 0, 0, 0, 11585, 11585, 0, 0));
      pending_items.push_back(make_item(16'd65535, 0, 0, 0, 16384, 0, 0, 16384, 0));
      pending_items.push_back(make_item(16'd16384, 16384, 0, 0, 0, 16383, 181, 0, 0));
      pending_items.push_back(make_item(16'd16384, 16384, 0, 0, 0, 16384, 1, 0, 0));
      wait_drained();

      // Zero tolerance: identical quaternions now reach the zero-sine case.
      write_tolerance(16'd0);
      pending_items.push_back(make_item(16'd16384, 16384, 0, 0, 0, 16384, 0, 0, 0));
      pending_items.push_back(make_item(16'd16384, 16384, 0, 0, 0, 16384, 1, 0, 0));
      pending_items.push_back(make_item(16'd16384, 0, 16384, 0, 0, 0, -16384, 0, 0));
      add_random_items(250);
      wait_drained();

      // Largest tolerance with a mostly idle sender.
      write_tolerance(16'd65535);
      send_idle_pct = 72;
      add_random_items(150);
      wait_drained();

      write_tolerance(16'd200);
      send_idle_pct = 0;
      stall_pct = 72;
      add_random_items(250);
      wait_drained();

      write_tolerance(16'($urandom_range(2000)));
      send_idle_pct = 31;
      stall_pct = 31;
      add_random_items(250);
      wait_drained();

      // The receiver holds off for a long stretch while items keep coming,
      // so the pipeline fills and the input stalls.
      write_tolerance(16'd1);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_armed = 1'b1;
      add_random_items(150);
      wait_drained();

      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("quaternion_slerp_unit regression: pass");
      end else begin
         $display("quaternion_slerp_unit regression: fail");
      end
      $finish;
   end

endmodule
